@@ src/shrdr_pkg.sv @@
package shrdr_pkg;

	localparam logic [31:0] VALID_EPOCH_MIN = 32'd1000000000;
	localparam logic [31:0] INTERVAL_RESET  = 32'd60000;
	localparam int unsigned MIN_STEP        = 2;
	localparam int unsigned DIV_W           = 17;

	localparam logic REG_SAMPLE_INTERVAL = 1'b0;

	localparam logic [2:0] ST_POINT        = 3'd0;
	localparam logic [2:0] ST_EMPTY        = 3'd1;
	localparam logic [2:0] ST_RECORDED     = 3'd2;
	localparam logic [2:0] ST_SKIP_INTERVAL = 3'd3;
	localparam logic [2:0] ST_SKIP_INVALID = 3'd4;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [31:0] now_ms;
		logic [31:0] epoch;
		logic [31:0] weight_bits;
		logic [31:0] since_epoch;
		logic [15:0] max_points;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] point_epoch;
		logic [31:0] point_weight_bits;
		logic        last;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RECORD,
		S_SCAN_INIT,
		S_SCAN,
		S_CHECK,
		S_DIV,
		S_EMIT_INIT,
		S_EMIT,
		S_EMPTY
	} state_t;

	typedef struct packed {
		logic accept;
		logic rec;
		logic walk_init;
		logic walk_en;
		logic count;
		logic div_start;
		logic step_set;
		logic emit;
		logic empty;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic walk_done;
		logic no_match;
		logic need_div;
		logic div_idle;
	} stat_t;

endpackage

@@ src/shrdr_ctrl.sv @@
module shrdr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_op,
	input  shrdr_pkg::stat_t stat,
	output shrdr_pkg::cmd_t  cmd,
	output logic             in_stall
);

	shrdr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shrdr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			shrdr_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = (in_op == shrdr_pkg::OP_QUERY) ? shrdr_pkg::S_SCAN_INIT
						: shrdr_pkg::S_RECORD;
				end
			end
			shrdr_pkg::S_RECORD: begin
				if (stat.out_free) state_d = shrdr_pkg::S_IDLE;
			end
			shrdr_pkg::S_SCAN_INIT: state_d = shrdr_pkg::S_SCAN;
			shrdr_pkg::S_SCAN: begin
				if (stat.walk_done) state_d = shrdr_pkg::S_CHECK;
			end
			shrdr_pkg::S_CHECK: begin
				priority if (stat.no_match) state_d = shrdr_pkg::S_EMPTY;
				else if (stat.need_div) state_d = shrdr_pkg::S_DIV;
				else state_d = shrdr_pkg::S_EMIT_INIT;
			end
			shrdr_pkg::S_DIV: begin
				if (stat.div_idle) state_d = shrdr_pkg::S_EMIT_INIT;
			end
			shrdr_pkg::S_EMIT_INIT: state_d = shrdr_pkg::S_EMIT;
			shrdr_pkg::S_EMIT: begin
				if (stat.walk_done) state_d = shrdr_pkg::S_IDLE;
			end
			shrdr_pkg::S_EMPTY: begin
				if (stat.out_free) state_d = shrdr_pkg::S_IDLE;
			end
			default: state_d = shrdr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			shrdr_pkg::S_IDLE: begin
				in_stall = 1'b0;
				cmd.accept = in_valid;
			end
			shrdr_pkg::S_RECORD: cmd.rec = stat.out_free;
			shrdr_pkg::S_SCAN_INIT: cmd.walk_init = 1'b1;
			shrdr_pkg::S_SCAN: begin
				cmd.walk_en = 1'b1;
				cmd.count = 1'b1;
			end
			shrdr_pkg::S_CHECK: cmd.div_start = stat.need_div;
			shrdr_pkg::S_DIV: ;
			shrdr_pkg::S_EMIT_INIT: begin
				cmd.walk_init = 1'b1;
				cmd.step_set = 1'b1;
			end
			shrdr_pkg::S_EMIT: begin
				cmd.walk_en = stat.out_free;
				cmd.emit = 1'b1;
			end
			shrdr_pkg::S_EMPTY: cmd.empty = stat.out_free;
			default: ;
		endcase
	end

endmodule

@@ src/shrdr_dp.sv @@
module shrdr_dp #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  shrdr_pkg::cmd_t       cmd,
	output shrdr_pkg::stat_t      stat,
	input  shrdr_pkg::in_item_t   in_data,
	input  logic [31:0]           interval,
	output logic                  out_valid,
	input  logic                  out_stall,
	output shrdr_pkg::out_item_t  out_data
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned NW = shrdr_pkg::DIV_W;
	localparam int unsigned DCW = $clog2(NW + 1);

	logic [63:0] mem [DEPTH];

	shrdr_pkg::in_item_t  in_q;
	shrdr_pkg::out_item_t out_q;
	logic                 out_valid_q;

	logic [AW-1:0] wp_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   last_time_q;

	logic [AW-1:0] rp_q;
	logic [CW-1:0] idx_q;
	logic          valid_s1;
	logic [63:0]   rd_s1;

	logic [CW-1:0] matches_q;
	logic [CW-1:0] matched_q;
	logic [CW-1:0] phase_q;
	logic [CW-1:0] step_q;

	logic [NW-1:0]  rem_q;
	logic [NW-1:0]  num_q;
	logic [DCW-1:0] dcnt_q;

	logic          out_free;
	logic          issue;
	logic          full;
	logic [AW-1:0] rp_next;
	logic [31:0]   rd_epoch;
	logic          rd_match;
	logic          is_last;
	logic          emit_load;
	logic [31:0]   diff;
	logic          skip_interval;
	logic          skip_invalid;
	logic [NW-1:0] divisor;
	logic [NW-1:0] rem_sh;
	logic          qbit;
	logic [CW-1:0] phase_inc;

	assign out_free = !out_valid_q || !out_stall;
	assign full     = (cnt_q == CW'(DEPTH));
	assign issue    = (idx_q != cnt_q);
	assign rp_next  = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign rd_epoch = rd_s1[63:32];
	assign rd_match = (in_q.since_epoch == 32'd0) || (rd_epoch >= in_q.since_epoch);
	assign is_last  = (matched_q == matches_q - CW'(1));
	assign phase_inc = phase_q + CW'(1);
	assign emit_load = cmd.emit && cmd.walk_en && valid_s1 && rd_match
		&& ((phase_q == '0) || is_last);

	assign diff          = in_q.now_ms - last_time_q;
	assign skip_interval = (diff < interval);
	assign skip_invalid  = (in_q.epoch < shrdr_pkg::VALID_EPOCH_MIN);

	assign divisor = NW'(in_q.max_points);
	assign rem_sh  = {rem_q[NW-2:0], num_q[NW-1]};
	assign qbit    = (rem_sh >= divisor);

	assign stat.out_free  = out_free;
	assign stat.walk_done = !issue && !valid_s1;
	assign stat.no_match  = (matches_q == '0);
	assign stat.need_div  = (in_q.max_points != 16'd0) && (NW'(matches_q) > divisor);
	assign stat.div_idle  = (dcnt_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.rec && !skip_interval && !skip_invalid) begin
			mem[wp_q] <= {in_q.epoch, in_q.weight_bits};
		end
		if (cmd.walk_en && issue) begin
			rd_s1 <= mem[rp_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) in_q <= in_data;
		priority if (cmd.rec) begin
			out_q.point_epoch       <= '0;
			out_q.point_weight_bits <= '0;
			out_q.last              <= 1'b1;
			priority if (skip_interval) out_q.status <= shrdr_pkg::ST_SKIP_INTERVAL;
			else if (skip_invalid) out_q.status <= shrdr_pkg::ST_SKIP_INVALID;
			else out_q.status <= shrdr_pkg::ST_RECORDED;
		end else if (cmd.empty) begin
			out_q.status            <= shrdr_pkg::ST_EMPTY;
			out_q.point_epoch       <= '0;
			out_q.point_weight_bits <= '0;
			out_q.last              <= 1'b1;
		end else if (emit_load) begin
			out_q.status            <= shrdr_pkg::ST_POINT;
			out_q.point_epoch       <= rd_epoch;
			out_q.point_weight_bits <= rd_s1[31:0];
			out_q.last              <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			wp_q        <= '0;
			cnt_q       <= '0;
			last_time_q <= '0;
			rp_q        <= '0;
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			matches_q   <= '0;
			matched_q   <= '0;
			phase_q     <= '0;
			step_q      <= '0;
			rem_q       <= '0;
			num_q       <= '0;
			dcnt_q      <= '0;
		end else begin
			if (cmd.rec || cmd.empty || emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.rec && !skip_interval) begin
				last_time_q <= in_q.now_ms;
				if (!skip_invalid) begin
					wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
					if (!full) cnt_q <= cnt_q + 1'b1;
				end
			end

			if (cmd.walk_init) begin
				rp_q     <= full ? wp_q : '0;
				idx_q    <= '0;
				valid_s1 <= 1'b0;
			end else if (cmd.walk_en) begin
				valid_s1 <= issue;
				if (issue) begin
					rp_q  <= rp_next;
					idx_q <= idx_q + 1'b1;
				end
			end

			if (cmd.walk_init && !cmd.step_set) begin
				matches_q <= '0;
			end else if (cmd.count && valid_s1 && rd_match) begin
				matches_q <= matches_q + 1'b1;
			end

			if (cmd.div_start) begin
				rem_q  <= '0;
				num_q  <= NW'(matches_q) + divisor - NW'(1);
				dcnt_q <= DCW'(NW);
			end else if (dcnt_q != '0) begin
				rem_q  <= qbit ? rem_sh - divisor : rem_sh;
				num_q  <= {num_q[NW-2:0], qbit};
				dcnt_q <= dcnt_q - 1'b1;
			end

			if (cmd.step_set) begin
				matched_q <= '0;
				phase_q   <= '0;
				if (!stat.need_div) begin
					step_q <= CW'(1);
				end else if (num_q < NW'(shrdr_pkg::MIN_STEP)) begin
					step_q <= CW'(shrdr_pkg::MIN_STEP);
				end else begin
					step_q <= num_q[CW-1:0];
				end
			end else if (cmd.emit && cmd.walk_en && valid_s1 && rd_match) begin
				matched_q <= matched_q + 1'b1;
				phase_q   <= (phase_inc == step_q) ? '0 : phase_inc;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("stored count exceeds depth");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rec || cmd.empty || emit_load) |-> out_free)
		else $error("result loaded over a held result");

	a_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.walk_en && !cmd.walk_init && issue) |=> valid_s1)
		else $error("issued read did not return data");

	a_matched_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (matched_q <= matches_q))
		else $error("emit pass saw more matches than counted");

endmodule

@@ src/sample_history_ring_decimated_readout_unit.sv @@
// Record: the result is loaded once the output is free, and no new item is accepted until
// it is. Query: the single read port walks the ring twice, first to count matches and then
// to emit, with a radix-2 division between the walks when decimation is needed; output
// stalls hold the emit walk. A waiting result does not block the next acceptance.
// Reset clears control state and sets the interval register to 60000; the sample store
// is not cleared and only written entries are ever read.
module sample_history_ring_decimated_readout_unit #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  shrdr_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output shrdr_pkg::out_item_t out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	shrdr_pkg::cmd_t  cmd;
	shrdr_pkg::stat_t stat;
	logic [31:0]      interval_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= shrdr_pkg::INTERVAL_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == shrdr_pkg::REG_SAMPLE_INTERVAL)) begin
			interval_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == shrdr_pkg::REG_SAMPLE_INTERVAL) ? interval_q : 32'd0;

	shrdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.operation),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	shrdr_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.interval  (interval_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
